@@ rtl/keyed_adpcm_block_decoder_top_macros.svh @@
// ----------------------------------------------------------------------------
// keyed_adpcm_block_decoder_top_macros
// assertion macros shared by the decoder rtl, empty under synthesis
// ----------------------------------------------------------------------------
`ifndef KEYED_ADPCM_BLOCK_DECODER_TOP_MACROS_SVH
`define KEYED_ADPCM_BLOCK_DECODER_TOP_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define KABD_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// condition must never be seen outside reset
`define KABD_NEVER(name, cond, msg) \
   name: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);
`else
`define KABD_ASSERT(name, prop, msg)
`define KABD_NEVER(name, cond, msg)
`endif
`endif

@@ rtl/kabd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kabd_pkg
// types, register codes and helpers shared by the keyed adpcm block decoder
// ----------------------------------------------------------------------------
package kabd_pkg;

   // configuration register indexes
   localparam logic [2:0] REG_COEF_A    = 3'd0;
   localparam logic [2:0] REG_COEF_B    = 3'd1;
   localparam logic [2:0] REG_KEY_START = 3'd2;
   localparam logic [2:0] REG_KEY_MUL   = 3'd3;
   localparam logic [2:0] REG_KEY_INC   = 3'd4;
   localparam logic [2:0] REG_MODE      = 3'd5;

   // output modes
   localparam logic [1:0] MODE_MONO   = 2'd0;
   localparam logic [1:0] MODE_STEREO = 2'd1;

   localparam logic [4:0] POS_HDR_HIGH = 5'd0;
   localparam logic [4:0] POS_HDR_LOW  = 5'd1;
   localparam logic [4:0] POS_FIRST    = 5'd2;
   localparam logic [4:0] POS_LAST     = 5'd17;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   // ceil(2^23 / 10), exact division by ten for magnitudes below 2^19
   localparam logic [19:0] MIX_RECIP = 20'd838861;

   typedef enum logic [1:0] {
      F_IDLE,
      F_LEFT_HDR,
      F_RIGHT_HDR
   } kabd_front_state_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_MUL,
      B_ACC,
      B_MIX,
      B_OUT
   } kabd_back_state_type;

   typedef struct packed {
      logic [7:0]  left_byte;
      logic [7:0]  right_byte;
      logic [13:0] left_scale;
      logic [13:0] right_scale;
      logic        last;
      logic        stream_end;
   } kabd_item_type;

   typedef struct packed {
      logic signed [15:0] coef_a;
      logic signed [15:0] coef_b;
      logic [1:0]         mode;
      logic               clear_hist;
   } kabd_cfg_type;

   function automatic logic signed [15:0] kabd_sat16(input logic signed [21:0] v);
      logic signed [15:0] r;
      if (v > 22'sd32767) begin
         r = 16'sh7FFF;
      end else if (v < -22'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

endpackage

@@ rtl/kabd_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kabd_front
// takes requests, tracks frame position, decodes headers, steps the key and
// queues sample bytes with their scales for the back end
// ----------------------------------------------------------------------------
module kabd_front
   import kabd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  logic [7:0]    req_left_byte,
   input  logic [7:0]    req_right_byte,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [2:0]    csr_index,
   input  logic [15:0]   csr_wdata,
   input  logic          q_full,
   output logic          q_push,
   output kabd_item_type q_item,
   output kabd_cfg_type  cfg
);

   kabd_front_state_type state_ff, state_in;
   logic [4:0]  pos_ff, pos_in;
   logic        ended_ff, ended_in;
   logic [15:0] lhdr_ff, lhdr_in;
   logic [15:0] rhdr_ff, rhdr_in;
   logic [13:0] lscale_ff, lscale_in;
   logic [13:0] rscale_ff, rscale_in;
   logic [14:0] key_ff, key_in;

   logic signed [15:0] coef_a_ff, coef_b_ff;
   logic [15:0] key_mul_ff, key_inc_ff;
   logic [1:0]  mode_ff;

   logic        csr_write;
   logic        key_load;
   logic        stereo;
   logic [29:0] key_prod;
   logic [14:0] key_next;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign key_load  = csr_write && (csr_index == REG_KEY_START);
   assign stereo    = (mode_ff != MODE_MONO);

   // key step, only the low 15 bits survive the modulo
   assign key_prod = key_mul_ff[14:0] * key_ff;
   assign key_next = key_inc_ff[14:0] + key_prod[14:0];

   assign cfg.coef_a     = coef_a_ff;
   assign cfg.coef_b     = coef_b_ff;
   assign cfg.mode       = mode_ff;
   assign cfg.clear_hist = key_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_a_ff  <= '0;
         coef_b_ff  <= '0;
         key_mul_ff <= '0;
         key_inc_ff <= '0;
         mode_ff    <= MODE_MONO;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_COEF_A:  coef_a_ff  <= csr_wdata;
            REG_COEF_B:  coef_b_ff  <= csr_wdata;
            REG_KEY_MUL: key_mul_ff <= csr_wdata;
            REG_KEY_INC: key_inc_ff <= csr_wdata;
            REG_MODE:    mode_ff    <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= F_IDLE;
         pos_ff    <= POS_HDR_HIGH;
         ended_ff  <= 1'b0;
         lscale_ff <= 14'd1;
         rscale_ff <= 14'd1;
         key_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         pos_ff    <= pos_in;
         ended_ff  <= ended_in;
         lscale_ff <= lscale_in;
         rscale_ff <= rscale_in;
         key_ff    <= key_in;
      end
   end

   always_ff @(posedge clock) begin
      lhdr_ff <= lhdr_in;
      rhdr_ff <= rhdr_in;
   end

   always_comb begin
      state_in  = state_ff;
      pos_in    = pos_ff;
      ended_in  = ended_ff;
      lhdr_in   = lhdr_ff;
      rhdr_in   = rhdr_ff;
      lscale_in = lscale_ff;
      rscale_in = rscale_ff;
      key_in    = key_ff;
      q_push    = 1'b0;
      q_item.left_byte   = req_left_byte;
      q_item.right_byte  = req_right_byte;
      q_item.left_scale  = lscale_ff;
      q_item.right_scale = rscale_ff;
      q_item.last        = (pos_ff >= POS_LAST);
      q_item.stream_end  = 1'b0;
      req_stall = (state_ff != F_IDLE) || q_full;

      unique case (state_ff)
         F_IDLE: begin
            // after an end header requests are taken and dropped
            if (req_valid && !req_stall && !ended_ff) begin
               if (pos_ff == POS_HDR_HIGH) begin
                  lhdr_in[15:8] = req_left_byte;
                  rhdr_in[15:8] = req_right_byte;
                  pos_in        = POS_HDR_LOW;
               end else if (pos_ff == POS_HDR_LOW) begin
                  lhdr_in[7:0] = req_left_byte;
                  rhdr_in[7:0] = req_right_byte;
                  state_in     = F_LEFT_HDR;
               end else begin
                  q_push = 1'b1;
                  pos_in = q_item.last ? POS_HDR_HIGH : pos_ff + 5'd1;
               end
            end
         end
         F_LEFT_HDR: begin
            if (lhdr_ff[15]) begin
               if (!q_full) begin
                  q_push            = 1'b1;
                  q_item.last       = 1'b0;
                  q_item.stream_end = 1'b1;
                  ended_in          = 1'b1;
                  pos_in            = POS_HDR_HIGH;
                  state_in          = F_IDLE;
               end
            end else begin
               lscale_in = {1'b0, lhdr_ff[12:0] ^ key_ff[12:0]} + 14'd1;
               key_in    = key_next;
               if (stereo) begin
                  state_in = F_RIGHT_HDR;
               end else begin
                  pos_in   = POS_FIRST;
                  state_in = F_IDLE;
               end
            end
         end
         F_RIGHT_HDR: begin
            // key already holds the left frame's step
            if (rhdr_ff[15]) begin
               if (!q_full) begin
                  q_push            = 1'b1;
                  q_item.last       = 1'b0;
                  q_item.stream_end = 1'b1;
                  ended_in          = 1'b1;
                  pos_in            = POS_HDR_HIGH;
                  state_in          = F_IDLE;
               end
            end else begin
               rscale_in = {1'b0, rhdr_ff[12:0] ^ key_ff[12:0]} + 14'd1;
               key_in    = key_next;
               pos_in    = POS_FIRST;
               state_in  = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase

      if (key_load) begin
         key_in   = csr_wdata[14:0];
         ended_in = 1'b0;
         pos_in   = POS_HDR_HIGH;
         state_in = F_IDLE;
      end
   end

endmodule

@@ rtl/kabd_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kabd_queue
// short fifo of decoded work items between front and back end
// ----------------------------------------------------------------------------
module kabd_queue
   import kabd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  kabd_item_type push_item,
   output logic          full,
   input  logic          pop,
   output logic          valid,
   output kabd_item_type pop_item
);

   kabd_item_type       store_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]     count_ff, count_in;

   assign full     = (count_ff == (QPTR_W + 1)'(QUEUE_DEPTH));
   assign valid    = (count_ff != '0);
   assign pop_item = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

@@ rtl/kabd_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kabd_back
// predictor and mixer: turns each queued byte pair into two sample responses,
// and each end item into one stream end response
module kabd_back
   import kabd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   output logic               q_pop,
   input  kabd_item_type      q_item,
   input  kabd_cfg_type       cfg,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_left_sample,
   output logic signed [15:0] rsp_right_sample,
   output logic               rsp_frame_done,
   output logic               rsp_stream_end
);

   kabd_back_state_type state_ff, state_in;
   kabd_item_type       item_ff, item_in;
   logic                half_ff, half_in;

   logic signed [15:0] lh0_ff, lh0_in, lh1_ff, lh1_in;
   logic signed [15:0] rh0_ff, rh0_in, rh1_ff, rh1_in;

   logic signed [31:0] pa_l_ff, pb_l_ff, pa_r_ff, pb_r_ff;
   logic signed [15:0] sl_ff, sl_in, sr_ff, sr_in;
   logic [38:0]        mixprod_ff;
   logic               mixneg_ff;

   logic               out_valid_ff, out_valid_in;
   logic signed [15:0] out_left_ff, out_left_in;
   logic signed [15:0] out_right_ff, out_right_in;
   logic               out_done_ff, out_done_in;
   logic               out_end_ff, out_end_in;

   logic               stereo, mixed, out_free, load;
   logic signed [3:0]  nib_l, nib_r;
   logic signed [15:0] acc_l, acc_r;
   logic signed [16:0] mix_sum;
   logic signed [19:0] mix_x7;
   logic [19:0]        mix_abs;
   logic [15:0]        mix_q;
   logic signed [16:0] mix_val;
   logic signed [15:0] mix_sat;

   // one sample: scale * nibble + floor((h1*b + h0*a) / 4096), saturated
   function automatic logic signed [15:0] predict(input logic signed [31:0] pa,
                                                  input logic signed [31:0] pb,
                                                  input logic [13:0] scale,
                                                  input logic signed [3:0] nib);
      logic signed [32:0] psum;
      logic signed [18:0] sn;
      logic signed [21:0] total;
      psum  = {pa[31], pa} + {pb[31], pb};
      sn    = $signed({1'b0, scale}) * nib;
      total = {psum[32], psum[32:12]} + {{3{sn[18]}}, sn};
      return kabd_sat16(total);
   endfunction

   assign stereo   = (cfg.mode != MODE_MONO);
   assign mixed    = cfg.mode[1];
   assign out_free = !out_valid_ff || !rsp_stall;

   assign nib_l = half_ff ? item_ff.left_byte[3:0] : item_ff.left_byte[7:4];
   assign nib_r = half_ff ? item_ff.right_byte[3:0] : item_ff.right_byte[7:4];
   assign acc_l = predict(pa_l_ff, pb_l_ff, item_ff.left_scale, nib_l);
   assign acc_r = predict(pa_r_ff, pb_r_ff, item_ff.right_scale, nib_r);

   // mix: 7*(l+r)/10 toward zero, divide on the magnitude by reciprocal
   assign mix_sum = {sl_ff[15], sl_ff} + {sr_ff[15], sr_ff};
   assign mix_x7  = {mix_sum, 3'b000} - {{3{mix_sum[16]}}, mix_sum};
   assign mix_abs = mix_x7[19] ? 20'(-mix_x7) : 20'(mix_x7);
   assign mix_q   = mixprod_ff[38:23];
   assign mix_val = mixneg_ff ? -$signed({1'b0, mix_q}) : $signed({1'b0, mix_q});
   assign mix_sat = kabd_sat16({{5{mix_val[16]}}, mix_val});

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      half_in      = half_ff;
      lh0_in       = lh0_ff;
      lh1_in       = lh1_ff;
      rh0_in       = rh0_ff;
      rh1_in       = rh1_ff;
      sl_in        = sl_ff;
      sr_in        = sr_ff;
      q_pop        = 1'b0;
      load         = 1'b0;
      out_left_in  = out_left_ff;
      out_right_in = out_right_ff;
      out_done_in  = out_done_ff;
      out_end_in   = out_end_ff;

      unique case (state_ff)
         B_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               item_in  = q_item;
               half_in  = 1'b0;
               state_in = q_item.stream_end ? B_OUT : B_MUL;
            end
         end
         B_MUL: state_in = B_ACC;
         B_ACC: begin
            sl_in  = acc_l;
            lh1_in = lh0_ff;
            lh0_in = acc_l;
            if (stereo) begin
               sr_in  = acc_r;
               rh1_in = rh0_ff;
               rh0_in = acc_r;
            end else begin
               sr_in = '0;
            end
            state_in = mixed ? B_MIX : B_OUT;
         end
         B_MIX: state_in = B_OUT;
         B_OUT: begin
            if (out_free) begin
               load = 1'b1;
               if (item_ff.stream_end) begin
                  out_left_in  = '0;
                  out_right_in = '0;
                  out_done_in  = 1'b0;
                  out_end_in   = 1'b1;
               end else begin
                  out_left_in  = mixed ? mix_sat : sl_ff;
                  out_right_in = mixed ? mix_sat : sr_ff;
                  out_done_in  = half_ff && item_ff.last;
                  out_end_in   = 1'b0;
               end
               if (item_ff.stream_end || half_ff) begin
                  state_in = B_IDLE;
               end else begin
                  half_in  = 1'b1;
                  state_in = B_MUL;
               end
            end
         end
         default: state_in = B_IDLE;
      endcase

      if (cfg.clear_hist) begin
         lh0_in = '0;
         lh1_in = '0;
         rh0_in = '0;
         rh1_in = '0;
      end

      if (load) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         half_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
         lh0_ff       <= '0;
         lh1_ff       <= '0;
         rh0_ff       <= '0;
         rh1_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         half_ff      <= half_in;
         out_valid_ff <= out_valid_in;
         lh0_ff       <= lh0_in;
         lh1_ff       <= lh1_in;
         rh0_ff       <= rh0_in;
         rh1_ff       <= rh1_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff      <= item_in;
      sl_ff        <= sl_in;
      sr_ff        <= sr_in;
      pa_l_ff      <= lh0_ff * $signed(cfg.coef_a);
      pb_l_ff      <= lh1_ff * $signed(cfg.coef_b);
      pa_r_ff      <= rh0_ff * $signed(cfg.coef_a);
      pb_r_ff      <= rh1_ff * $signed(cfg.coef_b);
      mixprod_ff   <= {19'd0, mix_abs} * {19'd0, MIX_RECIP};
      mixneg_ff    <= mix_x7[19];
      out_left_ff  <= out_left_in;
      out_right_ff <= out_right_in;
      out_done_ff  <= out_done_in;
      out_end_ff   <= out_end_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_left_sample  = out_left_ff;
   assign rsp_right_sample = out_right_ff;
   assign rsp_frame_done   = out_done_ff;
   assign rsp_stream_end   = out_end_ff;

endmodule

@@ rtl/keyed_adpcm_block_decoder_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_adpcm_block_decoder_top
// keyed 4-bit adpcm frame decoder, one byte pair per request
//
//   channel   dir  handshake           payload
//   req_      in   valid / stall       left_byte, right_byte
//   rsp_      out  valid / stall       left_sample, right_sample, frame_done,
//                                      stream_end
//   csr_      in   valid / ready       index, wdata
//
// the high header byte is stored; the low header byte then holds req_
// through the left header state and, in stereo, the right header state (one
// key step per cycle through the key multiplier). the back end gives each
// sample byte pair two rounds of predictor multiply and accumulate,
// optional mix, output load. front and back are split by a 2-entry queue;
// a stalled rsp_ stalls req_ only once the queue fills. reset is synchronous
// and returns config registers, key and histories to zero, scales to one.
// ----------------------------------------------------------------------------
`include "keyed_adpcm_block_decoder_top_macros.svh"
module keyed_adpcm_block_decoder_top
   import kabd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_left_byte,
   input  logic [7:0]         req_right_byte,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_left_sample,
   output logic signed [15:0] rsp_right_sample,
   output logic               rsp_frame_done,
   output logic               rsp_stream_end,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_wdata
);

   kabd_item_type push_item, pop_item;
   kabd_cfg_type  cfg;
   logic          q_push, q_full, q_pop, q_valid;
   logic          end_has_data;

   kabd_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_left_byte  (req_left_byte),
      .req_right_byte (req_right_byte),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_item         (push_item),
      .cfg            (cfg)
   );

   kabd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .pop_item  (pop_item)
   );

   kabd_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_valid),
      .q_pop            (q_pop),
      .q_item           (pop_item),
      .cfg              (cfg),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_left_sample  (rsp_left_sample),
      .rsp_right_sample (rsp_right_sample),
      .rsp_frame_done   (rsp_frame_done),
      .rsp_stream_end   (rsp_stream_end)
   );

   assign end_has_data = rsp_frame_done || (rsp_left_sample != 16'sd0) ||
                         (rsp_right_sample != 16'sd0);

   `KABD_NEVER(a_queue_overflow, q_push && q_full, "push into full queue")
   `KABD_NEVER(a_queue_underflow, q_pop && !q_valid, "pop from empty queue")
   `KABD_NEVER(a_end_fields_zero, rsp_valid && rsp_stream_end && end_has_data, "end with data")

endmodule
